// ----- rtl/raua_pkg.sv -----
package raua_pkg;

   // field widths of the channels
   localparam int FUNC_BITS      = 2;
   localparam int ANGLE_BITS     = 16;
   localparam int SENSE_BITS     = 2;
   localparam int LEVEL_BITS     = 17;
   localparam int ACC_BITS       = 24;
   localparam int THR_BITS       = 15;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 24;

   // request function codes
   localparam logic [FUNC_BITS-1:0] FUNC_UPDATE  = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_BIND    = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_RESTART = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_JUMP_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FULL_RANGE     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_VALUE    = 2'd2;

   // register reset values
   localparam logic [THR_BITS-1:0] THR_RESET   = 15'd12868;
   localparam longint unsigned     RANGE_RESET = 64'd25736;

   // 2*pi in Q.30, rounded
   localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

   // level value that stands for 1.0
   localparam logic [LEVEL_BITS-1:0] LEVEL_ONE = 17'd65536;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- rtl/raua_ifs.sv -----
interface raua_req_if;
   logic                                   valid;
   logic                                   ready;
   logic        [raua_pkg::FUNC_BITS-1:0]  func;
   logic signed [raua_pkg::ANGLE_BITS-1:0] angle;
   logic signed [raua_pkg::SENSE_BITS-1:0] sense;

   modport source (output valid, func, angle, sense, input ready);
   modport sink   (input valid, func, angle, sense, output ready);
endinterface

interface raua_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [raua_pkg::LEVEL_BITS-1:0]  level;
   logic [raua_pkg::ACC_BITS-1:0]    accumulated;

   modport source (output valid, level, accumulated, input ready);
   modport sink   (input valid, level, accumulated, output ready);
endinterface

interface raua_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [raua_pkg::CSR_INDEX_BITS-1:0]  index;
   logic [raua_pkg::CSR_DATA_BITS-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/raua_div.sv -----
// Restoring divider, one quotient bit per cycle: quotient = numer * 2^16 / denom,
// with numer <= denom so the quotient fits LEVEL_BITS.
module raua_div #(
   parameter int TOTAL_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  raua_pkg::div_ctrl_type                ctrl,
   input  logic [TOTAL_BITS-1:0]                 numer,
   input  logic [TOTAL_BITS-1:0]                 denom,
   output raua_pkg::div_stat_type                stat,
   output logic [raua_pkg::LEVEL_BITS-1:0]       quotient
);

   localparam int STEPS = raua_pkg::LEVEL_BITS;
   localparam int CNT_W = $clog2(STEPS);

   logic                             busy_ff;
   logic                             done_ff;
   logic [CNT_W-1:0]                 cnt_ff;
   logic [TOTAL_BITS:0]              rem_ff;
   logic [TOTAL_BITS-1:0]            den_ff;
   logic [raua_pkg::LEVEL_BITS-1:0]  quo_ff;

   logic                             bit_in;
   logic [TOTAL_BITS:0]              diff_in;
   logic [TOTAL_BITS:0]              rem_in;

   always_comb begin
      diff_in = rem_ff - {1'b0, den_ff};
      bit_in  = (rem_ff >= {1'b0, den_ff});
      // remainder stays below den, so the shifted value fits one extra bit
      rem_in  = bit_in ? {diff_in[TOTAL_BITS-1:0], 1'b0} : {rem_ff[TOTAL_BITS-1:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CNT_W'(STEPS - 1));
         if (ctrl.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == CNT_W'(STEPS - 1))) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         rem_ff <= {1'b0, numer};
         den_ff <= denom;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[raua_pkg::LEVEL_BITS-2:0], bit_in};
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < {den_ff, 1'b0})
      else $error("divider remainder out of bound");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

endmodule

// ----- rtl/rotary_angle_unwrap_accumulator.sv -----
// Channel   Dir  Ports        Word
// req       in   req_chan     func, angle, sense
// rsp       out  rsp_chan     level, accumulated
// csr       in   csr_chan     index, data (threshold, range, start value)
//
// Update with nonzero sense and restart: the rsp word passes PREP, ACCUM, DIVIDE, EMIT;
// no new accept before EMIT; the 17-step bit-serial divider in raua_div paces DIVIDE.
// Bind, still update and unused codes: the rsp word goes from PREP straight to EMIT.
// Reset (synchronous) loads register defaults, clears the accumulator and level.
// A waiting rsp word does not block the next accept; a finished word stalls
// only while the previous one is still held.
module rotary_angle_unwrap_accumulator #(
   parameter int ANGLE_FRAC_BITS = 12,
   parameter int TOTAL_BITS      = 24
) (
   input  logic        clock,
   input  logic        reset,
   raua_req_if.sink    req_chan,
   raua_rsp_if.source  rsp_chan,
   raua_csr_if.sink    csr_chan
);

   localparam longint unsigned TWO_PI_Q =
      ((raua_pkg::TWO_PI_Q30 >> (29 - ANGLE_FRAC_BITS)) + 64'd1) >> 1;
   localparam int TP_W  = $clog2(TWO_PI_Q + 1);
   localparam int LA_W  = (TP_W + 1 > 17) ? TP_W + 1 : 17;
   localparam int D_W   = LA_W + 2;
   localparam longint unsigned MAG_MAX =
      ((64'd1 << (raua_pkg::ANGLE_BITS - 1)) - 64'd1) + 2 * TWO_PI_Q;
   localparam int MAG_W = $clog2(MAG_MAX + 1);
   localparam int QB    = $clog2(MAG_MAX / TWO_PI_Q + 1);
   localparam int MD_W  = MAG_W + QB;
   localparam int MC_W  = $clog2(QB + 1);
   localparam int S_W   = ((TOTAL_BITS + 1 > D_W) ? TOTAL_BITS + 1 : D_W) + 1;
   localparam int RW    = (TOTAL_BITS > raua_pkg::CSR_DATA_BITS) ?
                          TOTAL_BITS : raua_pkg::CSR_DATA_BITS;

   localparam logic signed [D_W-1:0] TWO_PI_D     = D_W'(TWO_PI_Q);
   localparam logic [MD_W-1:0]       MOD_DSR_INIT = MD_W'(TWO_PI_Q << (QB - 1));
   localparam logic [RW-1:0]         TOTAL_MAX_RW = RW'({TOTAL_BITS{1'b1}});

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_ACCUM,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   state_type                                  state_ff;
   logic                                       rsp_valid_ff;
   logic [raua_pkg::LEVEL_BITS-1:0]            rsp_level_ff;
   logic [raua_pkg::ACC_BITS-1:0]              rsp_acc_ff;

   logic [raua_pkg::THR_BITS-1:0]              thr_ff;
   logic [TOTAL_BITS-1:0]                      range_ff;
   logic [raua_pkg::CSR_DATA_BITS-1:0]         start_ff;
   logic [TOTAL_BITS-1:0]                      total_ff;
   logic [raua_pkg::LEVEL_BITS-1:0]            scaled_ff;
   logic signed [LA_W-1:0]                     last_ff;

   logic [raua_pkg::FUNC_BITS-1:0]             func_ff;
   logic signed [raua_pkg::ANGLE_BITS-1:0]     angle_ff;
   logic signed [raua_pkg::SENSE_BITS-1:0]     sense_ff;
   logic signed [D_W-1:0]                      cur_ff;
   logic signed [D_W-1:0]                      diff_ff;
   logic [MAG_W-1:0]                           mag_ff;
   logic                                       neg_ff;
   logic [MD_W-1:0]                            dsr_ff;
   logic [MC_W-1:0]                            mod_cnt_ff;

   logic                                       req_fire;
   logic                                       csr_fire;
   logic                                       out_free;
   logic [RW-1:0]                              csr_data_rw;
   logic [TOTAL_BITS-1:0]                      csr_range_eff;

   logic signed [D_W-1:0]                      angle_d;
   logic signed [D_W-1:0]                      last_d;
   logic signed [D_W-1:0]                      thr_d;
   logic signed [D_W-1:0]                      diff0;
   logic signed [D_W-1:0]                      adj;
   logic signed [D_W-1:0]                      cur_in;
   logic signed [D_W-1:0]                      diff_in;

   logic signed [S_W-1:0]                      total_s;
   logic signed [S_W-1:0]                      dsum_s;
   logic signed [S_W-1:0]                      range_s;
   logic signed [S_W-1:0]                      sum_s;
   logic [TOTAL_BITS-1:0]                      total_in;

   logic signed [D_W-1:0]                      x_mod;
   logic [MAG_W-1:0]                           mag_in;
   logic [MD_W-1:0]                            mag_ext;
   logic signed [LA_W-1:0]                     mag_la;
   logic signed [LA_W-1:0]                     last_in;

   raua_pkg::div_ctrl_type                     div_ctrl;
   raua_pkg::div_stat_type                     div_stat;
   logic [raua_pkg::LEVEL_BITS-1:0]            div_quo;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_fire = csr_chan.valid && csr_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign csr_chan.ready       = 1'b1;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.level       = rsp_level_ff;
   assign rsp_chan.accumulated = rsp_acc_ff;

   // range is kept already limited to [1, 2^TOTAL_BITS - 1]
   always_comb begin
      csr_data_rw = RW'(csr_chan.data);
      if (csr_chan.data == '0) begin
         csr_range_eff = TOTAL_BITS'(1);
      end else if (csr_data_rw > TOTAL_MAX_RW) begin
         csr_range_eff = TOTAL_BITS'(TOTAL_MAX_RW);
      end else begin
         csr_range_eff = TOTAL_BITS'(csr_data_rw);
      end
   end

   // wrap detection
   always_comb begin
      angle_d = D_W'(angle_ff);
      last_d  = D_W'(last_ff);
      thr_d   = D_W'(thr_ff);
      diff0   = angle_d - last_d;
      if (sense_ff > 2'sd0 && diff0 < -thr_d) begin
         adj = TWO_PI_D;
      end else if (sense_ff < 2'sd0 && diff0 > thr_d) begin
         adj = -TWO_PI_D;
      end else begin
         adj = '0;
      end
      cur_in  = angle_d + adj;
      diff_in = diff0 + adj;
   end

   // clamped accumulate, or restart load
   always_comb begin
      total_s = S_W'(total_ff);
      dsum_s  = S_W'(diff_ff);
      range_s = S_W'(range_ff);
      sum_s   = total_s + dsum_s;
      if (func_ff == raua_pkg::FUNC_RESTART) begin
         total_in = (RW'(start_ff) > RW'(range_ff)) ? range_ff : TOTAL_BITS'(start_ff);
      end else if (sum_s < 0) begin
         total_in = '0;
      end else if (sum_s > range_s) begin
         total_in = range_ff;
      end else begin
         total_in = TOTAL_BITS'(sum_s);
      end
   end

   // truncating remainder: work on the magnitude, put the sign back at the end
   always_comb begin
      x_mod   = cur_ff + TWO_PI_D;
      mag_in  = MAG_W'(x_mod[D_W-1] ? -x_mod : x_mod);
      mag_ext = MD_W'(mag_ff);
      mag_la  = LA_W'(mag_ff);
      last_in = neg_ff ? -mag_la : mag_la;
   end

   assign div_ctrl.start = (state_ff == ST_ACCUM);

   raua_div #(
      .TOTAL_BITS (TOTAL_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .numer    (total_in),
      .denom    (range_ff),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= raua_pkg::THR_RESET;
         range_ff     <= TOTAL_BITS'(raua_pkg::RANGE_RESET);
         start_ff     <= '0;
         total_ff     <= '0;   // start value of zero, clamped
         scaled_ff    <= '0;
         last_ff      <= '0;
      end else begin
         if (csr_fire) begin
            unique case (csr_chan.index)
               raua_pkg::CSR_JUMP_THRESHOLD: thr_ff   <= csr_chan.data[raua_pkg::THR_BITS-1:0];
               raua_pkg::CSR_FULL_RANGE:     range_ff <= csr_range_eff;
               raua_pkg::CSR_START_VALUE:    start_ff <= csr_chan.data;
               default: ;
            endcase
         end

         if (state_ff == ST_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               unique case (func_ff)
                  raua_pkg::FUNC_UPDATE: begin
                     state_ff <= (sense_ff != 2'sd0) ? ST_ACCUM : ST_EMIT;
                  end
                  raua_pkg::FUNC_BIND: begin
                     last_ff  <= LA_W'(angle_ff);
                     state_ff <= ST_EMIT;
                  end
                  raua_pkg::FUNC_RESTART: begin
                     state_ff <= ST_ACCUM;
                  end
                  default: begin
                     state_ff <= ST_EMIT;
                  end
               endcase
            end
            ST_ACCUM: begin
               total_ff <= total_in;
               if (func_ff == raua_pkg::FUNC_RESTART) begin
                  last_ff <= '0;
               end
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (div_stat.done) begin
                  scaled_ff <= div_quo;
                  if (func_ff == raua_pkg::FUNC_UPDATE) begin
                     last_ff <= last_in;
                  end
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_level_ff <= scaled_ff;
                  rsp_acc_ff   <= raua_pkg::ACC_BITS'(total_ff);
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff  <= req_chan.func;
         angle_ff <= req_chan.angle;
         sense_ff <= req_chan.sense;
      end
      if (state_ff == ST_PREP) begin
         cur_ff  <= cur_in;
         diff_ff <= diff_in;
      end
      if (state_ff == ST_ACCUM) begin
         mag_ff     <= mag_in;
         neg_ff     <= x_mod[D_W-1];
         dsr_ff     <= MOD_DSR_INIT;
         mod_cnt_ff <= '0;
      end else if (state_ff == ST_DIVIDE && mod_cnt_ff < MC_W'(QB)) begin
         // one quotient bit of the remainder per cycle, beside the divider
         if (mag_ext >= dsr_ff) begin
            mag_ff <= MAG_W'(mag_ext - dsr_ff);
         end
         dsr_ff     <= dsr_ff >> 1;
         mod_cnt_ff <= mod_cnt_ff + MC_W'(1);
      end
   end

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside of divide state");

   a_mod_before_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> mod_cnt_ff == MC_W'(QB))
      else $error("angle remainder not finished with the level");

   a_total_clamped: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> total_ff <= range_ff)
      else $error("accumulator above range");

endmodule
